[src/wis_pkg.sv]
package wis_pkg;

  // field widths fixed by the interface
  localparam int TIME_W  = 16;
  localparam int TOTAL_W = 22;

  // one stored interval
  typedef struct packed {
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] start;
  } pair_t;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_SPAN,
    ALU_GT,
    ALU_ADDMAX
  } alu_op_t;

endpackage

[src/wis_ram.sv]
module wis_ram import wis_pkg::*; #(
  parameter int W  = 32,
  parameter int D  = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[src/wis_alu.sv]
module wis_alu import wis_pkg::*; #(
  parameter int W = 23
) (
  input  alu_op_t      op,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] z,
  output logic [W-1:0] res,
  output logic         flag
);

  logic [W-1:0] sum;
  logic         gt;

  assign gt  = x > y;
  assign sum = x + y;

  // span clamps at zero, addmax keeps the larger of x + y and z
  always_comb begin
    res  = '0;
    flag = 1'b0;
    unique case (op)
      ALU_SPAN: begin
        res  = gt ? (x - y) : '0;
        flag = gt;
      end
      ALU_GT: begin
        flag = gt;
      end
      ALU_ADDMAX: begin
        flag = sum > z;
        res  = flag ? sum : z;
      end
      default: begin
        res  = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

[src/weighted_interval_schedule.sv]
// Weighted interval scheduling, weight of an interval being its duration.
// Input channel (in_*): one interval per transfer, start and finish in tdata,
// tlast marks the final interval of a set. Each interval is put in place by
// insertion on arrival (stable by finish time), shifting up each stored
// interval with a later finish; the first interval goes straight in and a
// dropped interval is not stored.
// in_tready is low while an insertion or the table fill runs.
// Intervals beyond MAX_INTERVALS are dropped; their tlast still ends the set.
// After the last interval the table is filled over the sorted set with one
// shared add/compare unit, reading one earlier entry per cycle.
// Output channel (out_*): one transfer per set with the best total.
// The result sits in an output register; new intervals are accepted while it
// waits, and a following result holds the block until the first is taken.
// Reset (rst_n low, synchronous) empties the set and drops a pending result.
module weighted_interval_schedule import wis_pkg::*; #(
  parameter int MAX_INTERVALS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // start_time [15:0], finish_time [31:16]
  input  logic        in_tlast,   // last_interval
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // best_total [21:0], zero [23:22]
);

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int BW = TIME_W + CW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_F_RDI,
    S_F_GETI,
    S_F_MAXI,
    S_F_K,
    S_F_WR,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  pair_t               key_r, key_nxt;
  logic                last_r, last_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [TIME_W-1:0]   si_r, si_nxt;
  logic [BW-1:0]       d_r, d_nxt;
  logic [BW-1:0]       b_r, b_nxt;
  logic [BW-1:0]       prev_r, prev_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]  out_data_r, out_data_nxt;

  // memory ports
  logic                pair_we;
  logic [AW-1:0]       pair_waddr;
  pair_t               pair_wdata;
  pair_t               pair_rdata;
  logic                best_we;
  logic [AW-1:0]       rd_addr;
  logic [BW-1:0]       best_rdata;

  // shared unit
  alu_op_t             alu_op;
  logic [BW-1:0]       alu_x, alu_y, alu_z, alu_res;
  logic                alu_flag;

  logic                in_acc;
  pair_t               in_pair;
  logic [TOTAL_W+BW-1:0] b_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_pair    = in_tdata;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - TOTAL_W){1'b0}}, out_data_r};
  assign b_ext      = {{TOTAL_W{1'b0}}, b_r};

  wis_ram #(.W($bits(pair_t)), .D(MAX_INTERVALS), .AW(AW)) u_pair_ram (
    .clk     (clk),
    .we      (pair_we),
    .waddr   (pair_waddr),
    .wdata   (pair_wdata),
    .raddr   (rd_addr),
    .rdata_r (pair_rdata)
  );

  wis_ram #(.W(BW), .D(MAX_INTERVALS), .AW(AW)) u_best_ram (
    .clk     (clk),
    .we      (best_we),
    .waddr   (i_r),
    .wdata   (b_r),
    .raddr   (rd_addr),
    .rdata_r (best_rdata)
  );

  wis_alu #(.W(BW)) u_alu (
    .op   (alu_op),
    .x    (alu_x),
    .y    (alu_y),
    .z    (alu_z),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    si_nxt        = si_r;
    d_nxt         = d_r;
    b_nxt         = b_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pair_we       = 1'b0;
    pair_waddr    = j_r;
    pair_wdata    = key_r;
    best_we       = 1'b0;
    rd_addr       = k_r;
    alu_op        = ALU_GT;
    alu_x         = BW'(pair_rdata.finish);
    alu_y         = BW'(key_r.finish);
    alu_z         = b_r;

    // result register drains on transfer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt  = in_pair;
          last_nxt = in_tlast;
          i_nxt    = '0;
          prev_nxt = '0;
          if (count_r < CW'(MAX_INTERVALS)) begin
            j_nxt = count_r[AW-1:0];
            if (count_r == '0) begin
              // first entry goes straight in
              pair_we    = 1'b1;
              pair_waddr = '0;
              pair_wdata = in_pair;
              count_nxt  = count_r + CW'(1);
              state_nxt  = in_tlast ? S_F_RDI : S_IDLE;
            end else begin
              rd_addr   = count_r[AW-1:0] - AW'(1);
              state_nxt = S_INS_CMP;
            end
          end else begin
            // store full: drop the interval
            state_nxt = in_tlast ? S_F_RDI : S_IDLE;
          end
        end
      end

      S_INS_CMP: begin
        // entry j-1 is in pair_rdata; shift it up while its finish is later
        alu_op     = ALU_GT;
        pair_we    = 1'b1;
        pair_waddr = j_r;
        if (alu_flag) begin
          pair_wdata = pair_rdata;
          j_nxt      = j_r - AW'(1);
          if (j_r == AW'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            rd_addr = j_r - AW'(2);
          end
        end else begin
          pair_wdata = key_r;
          count_nxt  = count_r + CW'(1);
          state_nxt  = last_r ? S_F_RDI : S_IDLE;
        end
      end

      S_INS_PUT: begin
        pair_we    = 1'b1;
        pair_waddr = '0;
        pair_wdata = key_r;
        count_nxt  = count_r + CW'(1);
        state_nxt  = last_r ? S_F_RDI : S_IDLE;
      end

      S_F_RDI: begin
        if (count_r == '0) begin
          // empty set answers zero
          b_nxt     = '0;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = i_r;
          state_nxt = S_F_GETI;
        end
      end

      S_F_GETI: begin
        // duration of interval i
        alu_op    = ALU_SPAN;
        alu_x     = BW'(pair_rdata.finish);
        alu_y     = BW'(pair_rdata.start);
        d_nxt     = alu_res;
        si_nxt    = pair_rdata.start;
        state_nxt = S_F_MAXI;
      end

      S_F_MAXI: begin
        // taken alone, or the best of the previous row
        alu_op    = ALU_ADDMAX;
        alu_x     = d_r;
        alu_y     = '0;
        alu_z     = prev_r;
        b_nxt     = alu_res;
        k_nxt     = '0;
        rd_addr   = '0;
        state_nxt = (i_r == '0) ? S_F_WR : S_F_K;
      end

      S_F_K: begin
        // combine with an earlier compatible interval k
        alu_op = ALU_ADDMAX;
        alu_x  = d_r;
        alu_y  = best_rdata;
        alu_z  = b_r;
        if (si_r >= pair_rdata.finish) begin
          b_nxt = alu_res;
        end
        if (k_r == i_r - AW'(1)) begin
          state_nxt = S_F_WR;
        end else begin
          k_nxt   = k_r + AW'(1);
          rd_addr = k_r + AW'(1);
        end
      end

      S_F_WR: begin
        best_we  = 1'b1;
        prev_nxt = b_r;
        if (CW'(i_r) == count_r - CW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_F_RDI;
        end
      end

      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = b_ext[TOTAL_W-1:0];
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    si_r       <= si_nxt;
    d_r        <= d_nxt;
    b_r        <= b_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[verif/tb.sv]
module tb;
  import wis_pkg::*;

  localparam int MAX_HELD     = 64;
  localparam int RANDOM_ITEMS = 1700;
  // long enough for the fill of a full set of 64; a stray late result shows up within this
  localparam int DRAIN_CYCLES = 2500;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int MAX_REPORTS  = 50;

  // one pending input transfer and the idle cycles in front of it
  typedef struct {
    pair_t span;
    logic  last;
    int    gap;
  } interval_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // start_time [15:0], finish_time [31:16]
  logic        in_tlast;   // last_interval
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // best_total [21:0], zero [23:22]

  interval_item_t     interval_q[$];
  logic [TOTAL_W-1:0] best_q[$];

  // intervals of the set being received, in arrival order
  logic [TIME_W-1:0] set_start [MAX_HELD];
  logic [TIME_W-1:0] set_finish[MAX_HELD];
  int                set_len;

  interval_item_t     cur;
  logic               staged;
  int                 idle_left;
  int                 rx_wait;
  logic               in_taken;
  logic               out_taken;
  logic [TOTAL_W-1:0] want;
  int                 err_count;
  int                 cycle;
  int                 total_items;

  weighted_interval_schedule #(
    .MAX_INTERVALS(MAX_HELD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // best total duration of compatible intervals over the held set
  function automatic logic [TOTAL_W-1:0] max_busy_time(int n);
    logic [TIME_W-1:0] s_a[MAX_HELD];
    logic [TIME_W-1:0] f_a[MAX_HELD];
    logic [22:0]       tbl[MAX_HELD];
    logic [TIME_W-1:0] ks;
    logic [TIME_W-1:0] kf;
    logic [22:0]       b;
    logic [22:0]       c;
    logic [22:0]       d;
    int                i;
    int                j;
    int                k;
    for (i = 0; i < n; i++) begin
      s_a[i] = set_start[i];
      f_a[i] = set_finish[i];
    end
    // stable insertion sort by finish time
    for (i = 1; i < n; i++) begin
      ks = s_a[i];
      kf = f_a[i];
      j = i;
      while (j > 0 && f_a[j-1] > kf) begin
        s_a[j] = s_a[j-1];
        f_a[j] = f_a[j-1];
        j--;
      end
      s_a[j] = ks;
      f_a[j] = kf;
    end
    if (n == 0) begin
      return '0;
    end
    // table fill, a reversed interval counts as zero length
    tbl[0] = (f_a[0] > s_a[0]) ? 23'(f_a[0] - s_a[0]) : 23'd0;
    for (i = 1; i < n; i++) begin
      d = (f_a[i] > s_a[i]) ? 23'(f_a[i] - s_a[i]) : 23'd0;
      b = (d > tbl[i-1]) ? d : tbl[i-1];
      for (k = 0; k < i; k++) begin
        if (s_a[i] >= f_a[k]) begin
          c = d + tbl[k];
          if (c > b) begin
            b = c;
          end
        end
      end
      tbl[i] = b;
    end
    return tbl[n-1][TOTAL_W-1:0];
  endfunction

  task automatic push_interval(input int s, input int f, input logic last, input int gap);
    interval_item_t it;
    it.span.start  = TIME_W'(s);
    it.span.finish = TIME_W'(f);
    it.last = last;
    it.gap  = gap;
    interval_q.push_back(it);
    total_items++;
  endtask

  // one random set: mostly well formed spans, some raw noise and tiny clustered times
  task automatic push_random_set();
    int n;
    int mode;
    int calm;
    int s;
    int f;
    int i;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
    mode = $urandom_range(0, 9);
    calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      if (mode < 6) begin
        s = $urandom_range(0, 40000) + $urandom_range(0, 20000);
        f = s + $urandom_range(0, 5000);
        if (f > 65535) begin
          f = 65535;
        end
      end else if (mode < 8) begin
        s = $urandom_range(0, 15);
        f = $urandom_range(0, 15);
      end else begin
        s = $urandom_range(0, 65535);
        f = $urandom_range(0, 65535);
      end
      push_interval(s, f, (i == n - 1), calm ? 0 : $urandom_range(0, 8));
    end
  endtask

  // cycle count and watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver, one transfer per pending item
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (!staged && interval_q.size() > 0) begin
        cur = interval_q.pop_front();
        staged = 1'b1;
        idle_left = cur.gap;
      end
      if (staged && idle_left == 0) begin
        in_tdata  <= cur.span;
        in_tlast  <= cur.last;
        in_tvalid <= 1'b1;
        staged = 1'b0;
      end else begin
        in_tvalid <= 1'b0;
        if (staged) begin
          idle_left--;
        end
      end
    end
  end

  // result receiver with random stalls, calm stretches in between
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        rx_wait = (((cycle / 1500) % 4) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken  = in_tvalid && in_tready;
      out_taken = out_tvalid && out_tready;
      if (in_taken) begin
        // intervals past a full store are dropped, tlast still closes the set
        if (set_len < MAX_HELD) begin
          set_start[set_len]  = in_tdata[15:0];
          set_finish[set_len] = in_tdata[31:16];
          set_len++;
        end
        if (in_tlast) begin
          best_q.push_back(max_busy_time(set_len));
          set_len = 0;
        end
      end
      if (out_taken) begin
        if (best_q.size() == 0) begin
          if (err_count < MAX_REPORTS) begin
            $display("%0t unexpected result: expected none, actual best_total %0d",
                     $time, out_tdata[TOTAL_W-1:0]);
          end
          err_count++;
        end else begin
          want = best_q.pop_front();
          if (out_tdata[TOTAL_W-1:0] !== want) begin
            if (err_count < MAX_REPORTS) begin
              $display("%0t best_total mismatch: expected %0d, actual %0d",
                       $time, want, out_tdata[TOTAL_W-1:0]);
            end
            err_count++;
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    in_taken   = 1'b0;
    out_taken  = 1'b0;
    staged     = 1'b0;
    idle_left  = 0;
    rx_wait    = 0;
    set_len    = 0;
    err_count  = 0;
    cycle      = 0;
    total_items = 0;

    // directed: single extremes
    push_interval(0, 65535, 1'b1, $urandom_range(0, 8));
    push_interval(0, 0, 1'b1, $urandom_range(0, 8));
    push_interval(65535, 65535, 1'b1, 0);
    // finish before start clamps to zero
    push_interval(300, 100, 1'b1, $urandom_range(0, 8));
    push_interval(16'hAAAA, 16'h5555, 1'b0, 0);
    push_interval(16'h5555, 16'hAAAA, 1'b1, 0);
    // touching intervals are compatible
    push_interval(0, 10, 1'b0, 0);
    push_interval(10, 25, 1'b0, $urandom_range(0, 8));
    push_interval(25, 40, 1'b1, 0);
    // overlaps where the best pick is not the longest interval
    push_interval(0, 100, 1'b0, 0);
    push_interval(50, 60, 1'b0, 0);
    push_interval(60, 200, 1'b0, $urandom_range(0, 8));
    push_interval(90, 95, 1'b1, 0);
    // equal finish times and zero length intervals
    push_interval(5, 20, 1'b0, 0);
    push_interval(10, 20, 1'b0, 0);
    push_interval(20, 20, 1'b0, 0);
    push_interval(20, 30, 1'b1, $urandom_range(0, 8));
    // reversed intervals mixed into a set
    push_interval(500, 400, 1'b0, 0);
    push_interval(0, 400, 1'b0, 0);
    push_interval(400, 400, 1'b1, 0);

    while (total_items < RANDOM_ITEMS) begin
      push_random_set();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (interval_q.size() > 0 || staged || in_tvalid || best_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
